// File: hdl/u8kae_pkg.sv
// Shared types, constants and lookup functions of the UTF-8 keyed alphabet encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package u8kae_pkg;

    // Bytes one decode job can carry: a held lead, its followers and the new byte.
    localparam int JOB_BYTES = 4;

    // Depth of the result queue and the width of its pointers.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;

    // Key byte for units past the key, and the padding unit.
    localparam logic [7:0] PAD_VALUE = 8'd187;

    localparam logic [20:0] CP_BASE   = 21'h010000;
    localparam logic [15:0] SURR_HIGH = 16'hD800;
    localparam logic [15:0] SURR_LOW  = 16'hDC00;

    // Key bytes, first character in the top byte; the last byte is never read.
    localparam logic [8*16-1:0] KEY_TABLE = {"RDpbLfCPsJZ7fiv", 8'h00};

    // Alphabet of 255 characters plus a zero byte, first character in the top byte.
    localparam logic [8*256-1:0] ALPHA_TABLE = {
        "yLwVl0zKqws7LgKPRQ84Mdt708T1qQ3Ha7xv3H7NyU84p21BriUWBU43odz3iP4r",
        "BL3cD02KZciXTysVXiV8ngg6vL48rPJyAUw0HurW20xqxv9aYb4M9wK1Ae0wlro",
        "510qXeU07kV57fQMc8L6aLgMLwygtc0F10a0Dg70TOoouyFhdysuRMO51yY5ZlO",
        "ZZLEal1h0t9YQW0Ko7oBwmCAHoic4HYbUyVeU3sfQ1xtXcPcf1aT303wAQhv66qzW",
        8'h00
    };

    // One decode job handed from the front to the back.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      ending;
    } t_job;

    // One keyed unit on its way to the alphabet mapping.
    typedef struct packed {
        logic        valid;
        logic [15:0] value;
        logic        last;
    } t_unit;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DECODE,
        SEQ_LOW,
        SEQ_PAD
    } t_seq_state;

    // Number of continuation bytes a lead byte asks for.
    function automatic logic [1:0] follower_need(input logic [7:0] b);
        logic [1:0] need;
        case (b) inside
            [8'hC0:8'hDF]: need = 2'd1;
            [8'hE0:8'hEF]: need = 2'd2;
            [8'hF0:8'hF7]: need = 2'd3;
            default:       need = 2'd0;
        endcase
        return need;
    endfunction

    function automatic logic [7:0] key_byte(input logic [3:0] pos);
        logic [6:0] base;
        base = 7'(8 * (15 - int'(pos)));
        return KEY_TABLE[base +: 8];
    endfunction

    function automatic logic [7:0] alpha_char(input logic [7:0] idx);
        logic [10:0] base;
        base = 11'(8 * (255 - int'(idx)));
        return ALPHA_TABLE[base +: 8];
    endfunction

endpackage

`default_nettype wire

// File: hdl/u8kae_front.sv
// Front of the encoder: accepts text bytes, holds an unfinished UTF-8 sequence
// and issues decode jobs. Depends on u8kae_pkg.
`default_nettype none

module u8kae_front
    import u8kae_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    input  wire logic       i_text_empty,
    input  wire logic       i_job_full,
    output logic            o_job_push,
    output t_job            o_job
);

    logic [7:0] r_held [3];
    logic [1:0] r_held_cnt;
    logic [1:0] n_held_cnt;

    logic       w_accept;
    logic       w_ending;
    logic [1:0] w_need;

    assign o_full   = i_job_full;
    assign w_accept = i_push & ~i_job_full;
    assign w_ending = i_end_of_text | i_text_empty;

    always_comb begin
        o_job.bytes[0] = (r_held_cnt > 2'd0) ? r_held[0] : i_text_byte;
        o_job.bytes[1] = (r_held_cnt > 2'd1) ? r_held[1] : i_text_byte;
        o_job.bytes[2] = (r_held_cnt > 2'd2) ? r_held[2] : i_text_byte;
        o_job.bytes[3] = i_text_byte;
        o_job.count    = {1'b0, r_held_cnt} + {2'b00, ~i_text_empty};
        o_job.ending   = w_ending;
    end

    // The sequence is whole once the lead has all the followers it asks for.
    assign w_need     = follower_need(o_job.bytes[0]);
    assign o_job_push = w_accept & (w_ending | (w_need == r_held_cnt));

    always_comb begin
        n_held_cnt = r_held_cnt;
        if (o_job_push) begin
            n_held_cnt = 2'd0;
        end else if (w_accept) begin
            n_held_cnt = r_held_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
        end else begin
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !o_job_push && r_held_cnt != 2'd3) begin
            r_held[r_held_cnt] <= i_text_byte;
        end
    end

    // A held sequence always starts with a lead that still waits for followers.
    a_held_is_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 2'd0 |-> follower_need(r_held[0]) >= r_held_cnt)
        else $error("held bytes do not start with an open lead");

endmodule

`default_nettype wire

// File: hdl/u8kae_job_queue.sv
// Two-entry queue of decode jobs between the front and the back.
// Depends on u8kae_pkg.
`default_nettype none

module u8kae_job_queue
    import u8kae_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: hdl/u8kae_back.sv
// Back of the encoder: walks each decode job, forms UTF-16 units, applies the
// key and adds the end padding. Depends on u8kae_pkg.
`default_nettype none

module u8kae_back
    import u8kae_pkg::*;
#(
    parameter int KEY_SIZE = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_room,
    output t_unit     o_unit
);

    localparam logic [3:0] KEY_LEN = 4'(KEY_SIZE);

    t_seq_state                r_state, n_state;
    logic [JOB_BYTES-1:0][7:0] r_buf, n_buf;
    logic [2:0]                r_n, n_n;
    logic [2:0]                r_ptr, n_ptr;
    logic                      r_ending, n_ending;
    logic [9:0]                r_low, n_low;
    logic [3:0]                r_pos, n_pos;
    logic                      r_unit_valid;
    logic [15:0]               r_unit_value;
    logic                      r_unit_last;

    logic [7:0]  w_b0, w_b1, w_b2, w_b3;
    logic [1:0]  w_need;
    logic [2:0]  w_rem;
    logic        w_whole;
    logic [2:0]  w_adv;
    logic [2:0]  w_ptr_next;
    logic [20:0] w_cp;
    logic [20:0] w_v;
    logic        w_big;
    logic [15:0] w_high;
    logic [3:0]  w_pos_inc;
    logic [7:0]  w_key;
    logic        w_emit;
    logic [15:0] w_emit_unit;
    logic        w_emit_last;
    logic        w_finish;

    // Decode of the sequence that starts at the read pointer.
    assign w_b0 = r_buf[r_ptr[1:0]];
    assign w_b1 = r_buf[2'(r_ptr + 3'd1)];
    assign w_b2 = r_buf[2'(r_ptr + 3'd2)];
    assign w_b3 = r_buf[2'(r_ptr + 3'd3)];

    assign w_need     = follower_need(w_b0);
    assign w_rem      = r_n - r_ptr;
    assign w_whole    = w_rem > {1'b0, w_need};
    assign w_adv      = w_whole ? ({1'b0, w_need} + 3'd1) : 3'd1;
    assign w_ptr_next = r_ptr + w_adv;

    always_comb begin
        w_cp = {13'd0, w_b0};
        if (w_whole) begin
            case (w_need)
                2'd1:    w_cp = {10'd0, w_b0[4:0], w_b1[5:0]};
                2'd2:    w_cp = {5'd0, w_b0[3:0], w_b1[5:0], w_b2[5:0]};
                2'd3:    w_cp = {w_b0[2:0], w_b1[5:0], w_b2[5:0], w_b3[5:0]};
                default: w_cp = {13'd0, w_b0};
            endcase
        end
    end

    assign w_big  = (w_cp[20:16] != 5'd0);
    assign w_v    = w_cp - CP_BASE;
    assign w_high = SURR_HIGH | {5'd0, w_v[20:10]};

    assign w_pos_inc = (r_pos < KEY_LEN) ? (r_pos + 4'd1) : r_pos;
    assign w_key     = (r_pos < KEY_LEN) ? key_byte(r_pos) : PAD_VALUE;

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_n         = r_n;
        n_ptr       = r_ptr;
        n_ending    = r_ending;
        n_low       = r_low;
        n_pos       = r_pos;
        o_job_pop   = 1'b0;
        w_emit      = 1'b0;
        w_emit_unit = 16'h0000;
        w_emit_last = 1'b0;
        w_finish    = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_buf     = i_job.bytes;
                    n_n       = i_job.count;
                    n_ending  = i_job.ending;
                    n_ptr     = 3'd0;
                    n_state   = SEQ_DECODE;
                end
            end
            SEQ_DECODE: begin
                if (r_ptr >= r_n) begin
                    // An empty ending item: only padding may follow.
                    if (r_ending && r_pos < KEY_LEN) begin
                        n_state = SEQ_PAD;
                    end else begin
                        n_state = SEQ_IDLE;
                        if (r_ending) begin
                            n_pos = 4'd0;
                        end
                    end
                end else if (i_room) begin
                    w_emit = 1'b1;
                    n_ptr  = w_ptr_next;
                    if (w_big) begin
                        w_emit_unit = w_high;
                        n_low       = w_v[9:0];
                        n_pos       = w_pos_inc;
                        n_state     = SEQ_LOW;
                    end else begin
                        w_emit_unit = w_cp[15:0];
                        w_finish    = (w_ptr_next >= r_n);
                        if (!w_finish) begin
                            n_pos = w_pos_inc;
                        end
                    end
                end
            end
            SEQ_LOW: begin
                if (i_room) begin
                    w_emit      = 1'b1;
                    w_emit_unit = SURR_LOW | {6'd0, r_low};
                    w_finish    = (r_ptr >= r_n);
                    if (!w_finish) begin
                        n_pos   = w_pos_inc;
                        n_state = SEQ_DECODE;
                    end
                end
            end
            SEQ_PAD: begin
                if (i_room) begin
                    w_emit      = 1'b1;
                    w_emit_unit = {8'h00, PAD_VALUE};
                    w_emit_last = (w_pos_inc >= KEY_LEN);
                    if (w_emit_last) begin
                        n_pos   = 4'd0;
                        n_state = SEQ_IDLE;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase

        // The last unit of a job decides between padding, ending and waiting.
        if (w_finish) begin
            w_emit_last = r_ending && (w_pos_inc >= KEY_LEN);
            if (r_ending) begin
                if (w_pos_inc < KEY_LEN) begin
                    n_pos   = w_pos_inc;
                    n_state = SEQ_PAD;
                end else begin
                    n_pos   = 4'd0;
                    n_state = SEQ_IDLE;
                end
            end else begin
                n_pos   = w_pos_inc;
                n_state = SEQ_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SEQ_IDLE;
            r_pos        <= 4'd0;
            r_unit_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_unit_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf        <= n_buf;
        r_n          <= n_n;
        r_ptr        <= n_ptr;
        r_ending     <= n_ending;
        r_low        <= n_low;
        r_unit_value <= w_emit_unit ^ {8'h00, w_key};
        r_unit_last  <= w_emit_last;
    end

    assign o_unit = '{valid: r_unit_valid, value: r_unit_value, last: r_unit_last};

    // A surrogate pair takes all four bytes, so nothing remains behind it.
    a_low_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == SEQ_LOW |-> r_ptr == r_n)
        else $error("low surrogate pending with bytes left in the job");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= KEY_LEN)
        else $error("unit position beyond the key length");

    a_pad_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == SEQ_PAD |-> r_ending && r_pos < KEY_LEN)
        else $error("padding outside an ending job");

endmodule

`default_nettype wire

// File: hdl/u8kae_map.sv
// Alphabet mapping: reduces each keyed unit modulo the alphabet length in a short
// pipeline, looks up its character and queues the results. Depends on u8kae_pkg.
`default_nettype none

module u8kae_map
    import u8kae_pkg::*;
#(
    parameter int ALPHA_SIZE = 255
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_unit i_unit,
    output logic       o_room,
    input  wire logic  i_pop,
    output logic       o_empty,
    output logic [7:0] o_code_char,
    output logic       o_last_char
);

    // Quotient estimate by reciprocal; it is low by at most one.
    localparam logic [7:0]  ALEN  = 8'(ALPHA_SIZE);
    localparam logic [23:0] RECIP = 24'((2 ** 24) / ALPHA_SIZE);

    logic        r_a_valid;
    logic [15:0] r_a_x;
    logic [15:0] r_a_q;
    logic        r_a_last;
    logic        r_b_valid;
    logic [7:0]  r_b_rem;
    logic        r_b_last;

    logic [8:0]           r_q [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr;
    logic [OUT_PTR_W-1:0] r_rd;
    logic [OUT_PTR_W:0]   r_cnt;

    logic [39:0] w_prod;
    logic [23:0] w_qa;
    logic [15:0] w_diff;
    logic [8:0]  w_r9;
    logic [7:0]  w_rem;
    logic [5:0]  w_busy;
    logic        w_pop;

    assign w_prod = 40'(i_unit.value) * 40'(RECIP);
    assign w_qa   = 24'(r_a_q) * 24'(ALEN);
    assign w_diff = r_a_x - w_qa[15:0];
    assign w_r9   = w_diff[8:0];
    assign w_rem  = (w_r9 >= {1'b0, ALEN}) ? 8'(w_r9 - {1'b0, ALEN}) : w_r9[7:0];

    // Queue entries plus everything still on its way to the queue.
    assign w_busy = 6'(r_cnt) + 6'(r_a_valid) + 6'(r_b_valid) + 6'(i_unit.valid);
    assign o_room = (w_busy < 6'(OUT_DEPTH));

    assign o_empty     = (r_cnt == '0);
    assign o_code_char = r_q[r_rd][8:1];
    assign o_last_char = r_q[r_rd][0];
    assign w_pop       = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_cnt     <= '0;
        end else begin
            r_a_valid <= i_unit.valid;
            r_b_valid <= r_a_valid;
            if (r_b_valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (OUT_PTR_W + 1)'(r_b_valid) - (OUT_PTR_W + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x    <= i_unit.value;
        r_a_q    <= w_prod[39:24];
        r_a_last <= i_unit.last;
        r_b_rem  <= w_rem;
        r_b_last <= r_a_last;
        if (r_b_valid) begin
            r_q[r_wr] <= {alpha_char(r_b_rem), r_b_last};
        end
    end

    // Issue is gated on room, so the queue can never be written while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !w_pop |-> r_cnt < (OUT_PTR_W + 1)'(OUT_DEPTH))
        else $error("result queue written while full");

endmodule

`default_nettype wire

// File: hdl/utf8_keyed_alphabet_encoder_top.sv
// Top level of the UTF-8 keyed alphabet encoder.
// Instantiates u8kae_front, u8kae_job_queue, u8kae_back and u8kae_map; uses u8kae_pkg.
`default_nettype none

// The encoder takes the UTF-8 bytes of a text, one beat per byte, decodes them
// leniently into UTF-16 units (followers are never checked, surrogate pairs give
// two units), mixes unit i with key byte i (187 once past the key), and emits one
// alphabet character per unit. The end of a text is marked by end_of_text or by a
// beat with text_empty set; a lead still short of followers then stands for
// itself, and the output is padded up to KEY_SIZE characters, the final one
// carrying last_char, save when a text of KEY_SIZE units or more ends on a beat
// with no byte and nothing held. Both sides are queues: a beat enters when push
// is high and full is low, and a result leaves when pop is high and empty is low.
// The front takes a byte every cycle while its two-entry job queue has space; a
// job is one whole sequence, or whatever remains of a text on its final beat. The
// back sequencer loads each job and forms its units one after another before it
// takes the next one (an empty ending job still visits the decode state), and
// the final beat of a text adds the padding units. Each unit goes through the
// registered key mix, reciprocal multiply, remainder fix-up and table lookup into
// an eight-entry result queue; the back stops forming units while the entries of
// that queue and the units on their way to it fill it.
module utf8_keyed_alphabet_encoder_top
    import u8kae_pkg::*;
#(
    parameter int KEY_SIZE   = 15,
    parameter int ALPHA_SIZE = 255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    input  wire logic       i_text_empty,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_code_char,
    output logic            o_last_char
);

    // Front to queue.
    logic w_job_full;
    logic w_job_push;
    t_job w_job_in;

    // Queue to back.
    logic w_job_valid;
    logic w_job_pop;
    t_job w_job_out;

    // Back to mapping, with room flowing back.
    t_unit w_unit;
    logic  w_room;

    u8kae_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_text_empty  (i_text_empty),
        .i_job_full    (w_job_full),
        .o_job_push    (w_job_push),
        .o_job         (w_job_in)
    );

    u8kae_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_valid (w_job_valid),
        .o_job   (w_job_out)
    );

    u8kae_back #(
        .KEY_SIZE (KEY_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_room      (w_room),
        .o_unit      (w_unit)
    );

    u8kae_map #(
        .ALPHA_SIZE (ALPHA_SIZE)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_unit      (w_unit),
        .o_room      (w_room),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_code_char (o_code_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire
